>>> design/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared types and constants for the LRU key-value cache.
// ----------------------------------------------------------------------------
`default_nettype none

package lkvc_pkg;

  localparam int unsigned ENTRIES = 16;
  localparam int unsigned RANK_W  = $clog2(ENTRIES);
  localparam int unsigned OCC_W   = $clog2(ENTRIES + 1);
  localparam int unsigned CAP_W   = 5;
  localparam int unsigned EXT_W   = (CAP_W > OCC_W) ? CAP_W : OCC_W;
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned DATA_W  = 32;

  localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(16);
  localparam logic [DATA_W-1:0] MISS_VALUE = '1;

  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_PUT = 1'b1
  } lkvc_cmd_e;

  typedef struct packed {
    lkvc_cmd_e          cmd;
    logic [KEY_W-1:0]   key;
    logic [DATA_W-1:0]  value;
  } lkvc_req_t;

  typedef struct packed {
    logic               hit;
    logic [DATA_W-1:0]  value;
  } lkvc_rsp_t;

endpackage

`default_nettype wire

>>> design/lkvc_store.sv
// ----------------------------------------------------------------------------
// lkvc_store
// Entry array with parallel key match, rank update, eviction and insertion.
// Returns the response combinationally; state updates when go_i is high.
// ----------------------------------------------------------------------------
`default_nettype none

module lkvc_store (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          go_i,
  input  wire lkvc_pkg::lkvc_req_t     req_i,
  input  wire [lkvc_pkg::CAP_W-1:0]    cap_i,
  output lkvc_pkg::lkvc_rsp_t          rsp_o
);

  import lkvc_pkg::*;

  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [RANK_W-1:0]  rank_q [ENTRIES];
  logic [RANK_W-1:0]  rank_d [ENTRIES];
  logic [KEY_W-1:0]   key_q  [ENTRIES];
  logic [KEY_W-1:0]   key_d  [ENTRIES];
  logic [DATA_W-1:0]  value_q[ENTRIES];
  logic [DATA_W-1:0]  value_d[ENTRIES];
  logic [OCC_W-1:0]   occ_q, occ_d;

  logic [EXT_W-1:0]   cap_ext;
  logic [OCC_W-1:0]   eff_cap;
  logic [OCC_W-1:0]   cap_m1;
  logic               evict;
  logic [ENTRIES-1:0] match;
  logic               hit;
  logic [RANK_W-1:0]  hit_rank;
  logic [DATA_W-1:0]  hit_value;
  logic [ENTRIES-1:0] keep;
  logic [ENTRIES-1:0] slot_oh;
  logic               slot_found;
  logic [OCC_W-1:0]   occ_base;

  // capacity clamped to 1..ENTRIES
  always_comb begin
    cap_ext = EXT_W'(cap_i);
    if (cap_ext == '0) begin
      cap_ext = EXT_W'(1);
    end else if (cap_ext > EXT_W'(ENTRIES)) begin
      cap_ext = EXT_W'(ENTRIES);
    end
    eff_cap = OCC_W'(cap_ext);
    cap_m1  = eff_cap - OCC_W'(1);
    evict   = (occ_q >= eff_cap);
  end

  always_comb begin
    hit       = 1'b0;
    hit_rank  = '0;
    hit_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]  = valid_q[i] && (key_q[i] == req_i.key);
      hit       = hit | match[i];
      hit_rank  = hit_rank  | (rank_q[i]  & {RANK_W{match[i]}});
      hit_value = hit_value | (value_q[i] & {DATA_W{match[i]}});
    end
  end

  // survivors of an eviction and first free slot afterwards
  always_comb begin
    slot_found = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      keep[i]    = valid_q[i] && !(evict && (OCC_W'(rank_q[i]) >= cap_m1));
      slot_oh[i] = !keep[i] && !slot_found;
      slot_found = slot_found | !keep[i];
    end
    occ_base = evict ? cap_m1 : occ_q;
  end

  always_comb begin
    valid_d = valid_q;
    occ_d   = occ_q;
    for (int i = 0; i < ENTRIES; i++) begin
      rank_d[i]  = rank_q[i];
      key_d[i]   = key_q[i];
      value_d[i] = value_q[i];
    end
    if (go_i) begin
      if (hit) begin
        // promote: entries more recent than the hit age by one
        for (int i = 0; i < ENTRIES; i++) begin
          if (match[i]) begin
            rank_d[i] = '0;
            if (req_i.cmd == CMD_PUT) begin
              value_d[i] = req_i.value;
            end
          end else if (valid_q[i] && (rank_q[i] < hit_rank)) begin
            rank_d[i] = rank_q[i] + RANK_W'(1);
          end
        end
      end else if (req_i.cmd == CMD_PUT) begin
        for (int i = 0; i < ENTRIES; i++) begin
          valid_d[i] = keep[i];
          if (keep[i]) begin
            rank_d[i] = rank_q[i] + RANK_W'(1);
          end else if (valid_q[i]) begin
            rank_d[i] = '0;
          end
          if (slot_oh[i]) begin
            valid_d[i] = 1'b1;
            key_d[i]   = req_i.key;
            value_d[i] = req_i.value;
            rank_d[i]  = '0;
          end
        end
        occ_d = occ_base + OCC_W'(slot_found);
      end
    end
  end

  always_comb begin
    rsp_o.hit   = hit;
    rsp_o.value = ((req_i.cmd == CMD_GET) && hit) ? hit_value : MISS_VALUE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      occ_q   <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      occ_q   <= occ_d;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= rank_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ENTRIES; i++) begin
      key_q[i]   <= key_d[i];
      value_q[i] <= value_d[i];
    end
  end

endmodule

`default_nettype wire

>>> design/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key-value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// One request per clock unless the response side stalls. A request is
// registered, looked up against all entries in parallel once the output
// register can take a response, and its response is registered in the
// output register, which drives m_axis_tvalid_o. A response held by
// m_axis_tready_i low stalls the lookup, and once the input register is also
// full, s_axis_tready_o drops. The entry state is updated in the same cycle
// as the lookup, so back-to-back requests see each other's effects. The
// capacity register (1..16, reset 16, zero acts as one) must only be written
// while no request is in flight; lowering it takes effect on the next insert.
`default_nettype none

module lru_key_value_cache (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire [4:0]   cfg_wdata_i,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire [63:0]  s_axis_tdata_i,   // [31:0] lookup_key, [63:32] write_value
  input  wire         s_axis_tuser_i,   // [0] cmd (0 get, 1 put)
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] read_value
  output logic        m_axis_tuser_o    // [0] hit
);

  import lkvc_pkg::*;

  logic [CAP_W-1:0] cap_q;
  logic             in_valid_q, in_valid_d;
  lkvc_req_t        in_req_q;
  logic             out_valid_q, out_valid_d;
  lkvc_rsp_t        out_q;
  lkvc_rsp_t        rsp;
  logic             advance;
  logic             go;
  logic             s_accept;

  assign advance         = !out_valid_q || m_axis_tready_i;
  assign go              = in_valid_q && advance;
  assign s_axis_tready_o = !in_valid_q || advance;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  assign in_valid_d  = s_accept ? 1'b1 : (go ? 1'b0 : in_valid_q);
  assign out_valid_d = go ? 1'b1 : (m_axis_tready_i ? 1'b0 : out_valid_q);

  lkvc_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (go),
    .req_i  (in_req_q),
    .cap_i  (cap_q),
    .rsp_o  (rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CAP_RESET;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_req_q.cmd   <= lkvc_cmd_e'(s_axis_tuser_i);
      in_req_q.key   <= s_axis_tdata_i[KEY_W-1:0];
      in_req_q.value <= s_axis_tdata_i[KEY_W+DATA_W-1:KEY_W];
    end
    if (go) begin
      out_q <= rsp;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q.value;
  assign m_axis_tuser_o  = out_q.hit;

endmodule

`default_nettype wire

>>> tb/lkvc_checker.sv
// ----------------------------------------------------------------------------
// lkvc_checker
// Watches the request, response and capacity ports of the LRU key-value cache,
// keeps its own copy of the entry store and recency order, and checks every
// response against the oldest predicted one.
// ----------------------------------------------------------------------------
module lkvc_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  logic [63:0] req_data_i,   // [31:0] lookup_key, [63:32] write_value
  input  logic        req_user_i,   // [0] cmd
  input  logic        rsp_valid_i,
  input  logic        rsp_ready_i,
  input  logic [31:0] rsp_data_i,   // [31:0] read_value
  input  logic        rsp_user_i,   // [0] hit
  output int          outstanding_o,
  output int          fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import lkvc_pkg::*;

  logic              slot_valid [ENTRIES];
  logic [KEY_W-1:0]  slot_key   [ENTRIES];
  logic [DATA_W-1:0] slot_value [ENTRIES];
  int                slot_rank  [ENTRIES];
  int                occupancy;
  logic [CAP_W-1:0]  capacity;
  int                fails;

  lkvc_rsp_t         expected_rsps [$];

  // Entries more recent than idx age by one; idx becomes rank 0.
  function automatic void make_most_recent(int idx);
    int r;
    r = slot_rank[idx];
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_valid[i] && slot_rank[i] < r) slot_rank[i]++;
    end
    slot_rank[idx] = 0;
  endfunction

  function automatic lkvc_rsp_t cache_access(lkvc_cmd_e cmd, logic [KEY_W-1:0] key,
                                             logic [DATA_W-1:0] value);
    lkvc_rsp_t rsp;
    int        found;
    int        slot;
    int        cap;
    found = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (found < 0 && slot_valid[i] && slot_key[i] == key) found = i;
    end
    rsp.hit   = (found >= 0);
    rsp.value = MISS_VALUE;
    if (cmd == CMD_GET) begin
      if (found >= 0) begin
        rsp.value = slot_value[found];
        make_most_recent(found);
      end
      return rsp;
    end
    if (found >= 0) begin
      slot_value[found] = value;
      make_most_recent(found);
      return rsp;
    end
    // zero acts as one, anything above the entry count saturates
    cap = (capacity == 0) ? 1 : ((capacity > ENTRIES) ? ENTRIES : int'(capacity));
    if (occupancy >= cap) begin
      // a lowered capacity drops every entry of rank cap - 1 or more in one go
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_valid[i] && slot_rank[i] >= cap - 1) begin
          slot_valid[i] = 1'b0;
          slot_rank[i]  = 0;
        end
      end
      occupancy = cap - 1;
    end
    slot = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_valid[i]) slot_rank[i]++;
      else if (slot < 0) slot = i;
    end
    if (slot >= 0) begin
      slot_valid[slot] = 1'b1;
      slot_key[slot]   = key;
      slot_value[slot] = value;
      slot_rank[slot]  = 0;
      occupancy++;
    end
    return rsp;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lkvc_rsp_t want;
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        slot_valid[i] = 1'b0;
        slot_key[i]   = '0;
        slot_value[i] = '0;
        slot_rank[i]  = 0;
      end
      occupancy = 0;
      capacity  = CAP_RESET;
      fails     = 0;
      expected_rsps.delete();
    end else begin
      if (cfg_we_i) capacity = cfg_wdata_i;
      if (rsp_valid_i && rsp_ready_i) begin
        if (expected_rsps.size() == 0) begin
          $error("unexpected response: hit=%0b read_value=%h", rsp_user_i, rsp_data_i);
          fails++;
        end else begin
          want = expected_rsps.pop_front();
          if (rsp_user_i !== want.hit) begin
            $error("hit: expected %0b, got %0b", want.hit, rsp_user_i);
            fails++;
          end
          if (rsp_data_i !== want.value) begin
            $error("read_value: expected %h, got %h", want.value, rsp_data_i);
            fails++;
          end
        end
      end
      if (req_valid_i && req_ready_i) begin
        expected_rsps.push_back(cache_access(lkvc_cmd_e'(req_user_i), req_data_i[31:0],
                                             req_data_i[63:32]));
      end
    end
    outstanding_o <= expected_rsps.size();
    fail_count_o  <= fails;
  end

endmodule

>>> tb/lru_key_value_cache_tb.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache_tb
// Drives gets and puts into the LRU key-value cache over a series of capacity
// settings, with random idling on both streams in all but the last phase; the checker scores responses.
// ----------------------------------------------------------------------------
module lru_key_value_cache_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lkvc_pkg::*;

  localparam int WATCHDOG_CYCLES = 2000;
  localparam int PHASE_ITEMS     = 160;
  localparam int POOL_MAX        = 24;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [4:0]  cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic [63:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tready = 1'b0;
  wire         s_tready;
  wire         m_tvalid;
  wire  [31:0] m_tdata;
  wire         m_tuser;

  int          outstanding;
  int          fail_count;
  int          idle_cycles = 0;
  logic        quiet = 1'b0;

  always #4 clk_i = ~clk_i;

  lru_key_value_cache dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  lkvc_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .req_valid_i   (s_tvalid),
    .req_ready_i   (s_tready),
    .req_data_i    (s_tdata),
    .req_user_i    (s_tuser),
    .rsp_valid_i   (m_tvalid),
    .rsp_ready_i   (m_tready),
    .rsp_data_i    (m_tdata),
    .rsp_user_i    (m_tuser),
    .outstanding_o (outstanding),
    .fail_count_o  (fail_count)
  );

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // response side back-pressure
  initial begin
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (quiet) begin
        m_tready <= 1'b1;
        @(posedge clk_i);
      end else if ($urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 48)) @(posedge clk_i);
      end
    end
  end

  task automatic send_req(lkvc_cmd_e cmd, logic [31:0] key, logic [31:0] value);
    s_tvalid <= 1'b1;
    s_tdata  <= {value, key};
    s_tuser  <= cmd;
    do @(negedge clk_i); while (!s_tready);
    @(posedge clk_i);
  endtask

  task automatic hold_off(int cycles);
    s_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // drain everything in flight, then let the pipeline settle
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(negedge clk_i); while (outstanding != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [4:0] cap);
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  logic [4:0]  phase_caps [10] = '{5'd3, 5'd1, 5'd0, 5'd31, 5'd2, 5'd5, 5'd16, 5'd9,
                                   5'd12, 5'd16};
  logic [31:0] key_pool [POOL_MAX];

  initial begin
    int          pool_size;
    int          eff_cap;
    int          run_left;
    logic [31:0] key;
    lkvc_cmd_e   cmd;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty store, extreme keys and values, update, eviction at 16
    send_req(CMD_GET, 32'h8000_0000, 32'h0);
    send_req(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_req(CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_req(CMD_PUT, 32'h0000_0000, 32'h0000_0000);
    send_req(CMD_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(CMD_GET, 32'h8000_0000, 32'hDEAD_BEEF);
    send_req(CMD_GET, 32'hFFFF_FFFF, 32'h0);
    send_req(CMD_PUT, 32'h0000_0000, 32'h1234_5678);
    send_req(CMD_GET, 32'h0000_0000, 32'h0);
    send_req(CMD_GET, 32'h0000_0001, 32'h0);
    for (int i = 0; i < 13; i++) send_req(CMD_PUT, 32'h100 + i, $urandom());
    // least recent key has just been pushed out
    send_req(CMD_GET, 32'h7FFF_FFFF, 32'h0);

    run_left = $urandom_range(1, 40);
    foreach (phase_caps[p]) begin
      drain();
      write_capacity(phase_caps[p]);
      quiet <= (p == $size(phase_caps) - 1);
      eff_cap = (phase_caps[p] == 0) ? 1 : ((phase_caps[p] > 16) ? 16 : phase_caps[p]);
      pool_size = eff_cap + $urandom_range(1, 6);
      if (pool_size > POOL_MAX) pool_size = POOL_MAX;
      foreach (key_pool[k]) key_pool[k] = $urandom();
      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7FFF_FFFF;
      key_pool[2] = 32'h0000_0000;
      key_pool[3] = 32'hFFFF_FFFF;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p != $size(phase_caps) - 1) begin
          if (run_left == 0) begin
            if ($urandom_range(0, 1) == 0) hold_off($urandom_range(1, 16));
            run_left = $urandom_range(1, 40);
          end else begin
            run_left--;
          end
        end
        cmd = ($urandom_range(0, 1) == 0) ? CMD_GET : CMD_PUT;
        key = ($urandom_range(0, 15) == 0) ? $urandom()
                                           : key_pool[$urandom_range(0, pool_size - 1)];
        send_req(cmd, key, pick_value());
      end
    end

    s_tvalid <= 1'b0;
    do @(negedge clk_i); while (outstanding != 0);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
